### design/srpt_pkg.sv
// ---------------------------------------------------------------------------
// srpt_pkg: shared types and constants for the sorted recent post table
// Table depth, field widths, word layouts and controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package srpt_pkg;

  localparam int MAX_POSTS = 20;
  localparam int IDX_W     = $clog2(MAX_POSTS);
  localparam int CNT_W     = $clog2(MAX_POSTS + 1);

  localparam int TIME_W    = 32;
  localparam int HANDLE_W  = 16;
  localparam int POS_W     = 5;
  localparam int HELD_W    = 5;

  localparam int IN_W      = 48;
  localparam int OUT_W     = 16;
  localparam int OUT_PAD   = OUT_W - 1 - POS_W - HELD_W;

  typedef struct packed {
    logic [HANDLE_W-1:0]      handle;
    logic signed [TIME_W-1:0] stamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch new word, issue first read
    logic scan;    // one compare/move step
    logic place;   // write new entry, load result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // table holds nothing
    logic scan_stop;  // insertion point found this cycle
    logic out_free;   // result register can take a word
  } dp_stat_t;

endpackage

`default_nettype wire

### design/sorted_recent_post_table.sv
// Sequence: an accept step, then a scan over up to the held count of entries
//   (none on an empty table), then a place step that loads the result word.
// Input: a new word is taken only in idle, once the previous one is placed;
//   the scan walks the single read port of the entry memory one entry a cycle.
// Reset: synchronous, active low; clears the entry count, FSM and result
//   valid. Table contents are not cleared; only held entries are ever scanned.
// ---------------------------------------------------------------------------
// sorted_recent_post_table: timestamp-ordered table of recent posts
// Keeps up to MAX_POSTS (timestamp, handle) entries in ascending time order
// and reports, per post, whether it was kept, where, and the new fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_recent_post_table
  import srpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // [31:0] timestamp (signed), [47:32] post_handle
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // [0] accepted, [5:1] position,
                                            // [10:6] held_count, [15:11] zero
);

  // Flow per word:
  //  - partial table: walk down from the newest entry, moving each entry
  //    whose time is >= the new one up by one slot, stop at the first older
  //    entry; the new post lands just above it (ahead of equal times).
  //  - full table: walk up from the oldest, moving each strictly older entry
  //    down one slot (the oldest falls off); stop at the first entry not
  //    older. If that is the oldest itself the post is rejected.
  //  - the place cycle writes the new entry and loads the result word; it
  //    waits there while a previous result has not been taken.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  srpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### design/srpt_dp.sv
// ---------------------------------------------------------------------------
// srpt_dp: table datapath
// Entry memory, scan cursor, compare, shift moves and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module srpt_dp
  import srpt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata
);

  entry_t                   mem [MAX_POSTS];
  entry_t                   rd_data_r;

  logic [CNT_W-1:0]         count_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic signed [TIME_W-1:0] when_r;
  logic [HANDLE_W-1:0]      handle_r;
  logic                     full_r;
  logic                     ok_r;
  logic [IDX_W-1:0]         cur_r;
  logic [IDX_W-1:0]         place_r;

  logic [IDX_W-1:0]         cur_inc, cur_dec, last_idx, start_addr, step_addr, rd_addr;
  logic [IDX_W-1:0]         scan_place, wr_addr;
  logic                     hit, at_edge, reject, move_en, wr_en;
  entry_t                   wr_data;
  logic [CNT_W-1:0]         count_nxt;

  assign cur_inc    = IDX_W'(cur_r + 1'b1);
  assign cur_dec    = IDX_W'(cur_r - 1'b1);
  assign last_idx   = IDX_W'(count_r - 1'b1);
  assign start_addr = (count_r == CNT_W'(MAX_POSTS)) ? '0 : last_idx;

  // full table walks up from the oldest, otherwise down from the newest
  assign hit     = full_r ? (when_r > $signed(rd_data_r.stamp))
                          : ($signed(rd_data_r.stamp) >= when_r);
  assign at_edge = full_r ? (cur_r == last_idx) : (cur_r == '0);
  assign reject  = full_r && !hit && (cur_r == '0);

  assign step_addr  = full_r ? cur_inc : cur_dec;
  assign rd_addr    = cmd.start ? start_addr : step_addr;
  assign scan_place = full_r ? (hit ? cur_r : cur_dec)
                             : (hit ? '0 : cur_inc);

  assign move_en = cmd.scan && hit && (!full_r || (cur_r != '0));
  assign wr_en   = move_en || (cmd.place && ok_r);
  assign wr_addr = move_en ? (full_r ? cur_dec : cur_inc) : place_r;
  assign wr_data = move_en ? rd_data_r : entry_t'{handle: handle_r, stamp: when_r};

  assign count_nxt = full_r ? count_r : CNT_W'(count_r + 1'b1);

  assign stat.empty     = (count_r == '0);
  assign stat.scan_stop = !hit || at_edge;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.place) begin
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      when_r   <= $signed(in_tdata[TIME_W-1:0]);
      handle_r <= in_tdata[TIME_W +: HANDLE_W];
      full_r   <= (count_r == CNT_W'(MAX_POSTS));
      ok_r     <= 1'b1;
      place_r  <= '0;
      cur_r    <= start_addr;
    end else if (cmd.scan) begin
      cur_r <= step_addr;
      if (stat.scan_stop) begin
        place_r <= scan_place;
        ok_r    <= !reject;
      end
    end
    if (cmd.place) begin
      out_data_r <= {{OUT_PAD{1'b0}}, HELD_W'(count_nxt),
                     (ok_r ? POS_W'(place_r) : POS_W'(0)), ok_r};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POSTS))
    else $error("entry count above table depth");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place && !full_r |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("count did not grow on insert into partial table");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place && full_r |=> count_r == $past(count_r))
    else $error("count changed on full table");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (CNT_W'(cur_r) < count_r))
    else $error("scan cursor outside held entries");
`endif

endmodule

`default_nettype wire

### design/srpt_ctrl.sv
// ---------------------------------------------------------------------------
// srpt_ctrl: sequencing FSM
// Accepts a word, runs the scan, then places the entry and loads the result.
// ---------------------------------------------------------------------------
`default_nettype none

module srpt_ctrl
  import srpt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cmd.start = accept;
  assign cmd.scan  = (state_r == S_SCAN);
  assign cmd.place = (state_r == S_PLACE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= stat.empty ? S_PLACE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_stop) begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
